FILE: hw/rtl/cfc_pkg.sv
// Package for the CRC frame checker: result item type, status codes,
// byte-wide CRC-16/MODBUS update. No dependencies.
package cfc_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [8:0]  COUNT_MAX = 9'd511;
  localparam logic [9:0]  LEN_EXTRA = 10'd3;

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEN  = 2'd1,
    STATUS_BAD_CRC  = 2'd2,
    STATUS_NO_LINK  = 2'd3
  } frame_status_t;

  // One result item
  typedef struct packed {
    logic          is_status;
    logic [7:0]    payload_byte;
    frame_status_t frame_status;
    logic          run_last;
  } result_t;

  // Up to two result items written into the queue per transfer
  typedef struct packed {
    logic    a_en;
    logic    b_en;
    result_t a;
    result_t b;
  } push_t;

  // Reflected CRC-16 update, one byte, bit at a time unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/cfc_if.sv
// Handshake channels of the CRC frame checker: received bytes, results,
// configuration writes. Depends on cfc_pkg.
interface cfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface cfc_res_if;
  import cfc_pkg::*;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic       run_last;
  modport source (output valid, output is_status, output payload_byte,
                  output frame_status, output run_last, input ready);
  modport sink (input valid, input is_status, input payload_byte,
                input frame_status, input run_last, output ready);
endinterface

interface cfc_cfg_if;
  logic valid;
  logic ready;
  logic link_up;
  modport source (output valid, output link_up, input ready);
  modport sink (input valid, input link_up, output ready);
endinterface

FILE: hw/rtl/crc_frame_checker_unit.sv
// Top level of the CRC frame checker: framing state, CRC update and the
// result queue. Depends on cfc_pkg, cfc_if.sv and cfc_result_fifo.
//
// Use:
//   rx  : one frame byte per transfer: a length byte L, L payload bytes,
//         then the CRC-16/MODBUS low byte first; frame_end flags the last.
//   tx  : result items. Payload bytes come out delayed by two bytes, so the
//         CRC bytes never appear. The last byte adds a status item
//         (is_status = 1, run_last = 1): ok, bad length, bad CRC or not
//         connected. Discard the frame's payload unless the status is ok.
//   cfg : writes link_up; always ready. Write only while the block is idle.
// Output: a result is registered into the result queue and reaches tx from there.
// Throughput: one byte per cycle while the result queue has room; the CRC
//   step is a byte-wide unrolled update done within the transfer cycle. The
//   four-entry result queue takes a byte while it holds two or fewer items;
//   a frame end can push two items for one byte, which tx takes in turn.
// Reset: link down, frame state cleared, result queue emptied.
// Stall: when tx is held, the queue fills and rx ready drops; nothing lost.
module crc_frame_checker_unit
  import cfc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  cfc_cfg_if.sink   cfg,
  cfc_rx_if.sink    rx,
  cfc_res_if.source tx
);

  logic        link_up;
  logic [15:0] crc_acc;
  logic [8:0]  byte_count;
  logic [7:0]  declared_length;
  logic [7:0]  hold_bytes [2];
  logic [1:0]  hold_count;

  logic        rx_xfer;
  logic [15:0] crc_next;
  logic [8:0]  count_next;
  logic [7:0]  length_eff;
  logic        emit_payload;
  frame_status_t status_code;
  result_t     pay_item;
  result_t     stat_item;
  push_t       push;
  result_t     head;
  logic [2:0]  level;
  logic        tx_xfer;

  assign cfg.ready = 1'b1;
  assign rx.ready  = (level <= 3'd2);
  assign rx_xfer   = rx.valid & rx.ready;
  assign tx_xfer   = tx.valid & tx.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_up <= 1'b0;
    end else if (cfg.valid) begin
      link_up <= cfg.link_up;
    end
  end

  // Per-byte frame logic
  always_comb begin
    crc_next     = crc_byte(crc_acc, rx.rx_byte);
    count_next   = (byte_count < COUNT_MAX) ? byte_count + 9'd1 : byte_count;
    length_eff   = (byte_count == 9'd0) ? rx.rx_byte : declared_length;
    emit_payload = (byte_count != 9'd0) && (hold_count == 2'd2);
    priority if (!link_up) begin
      status_code = STATUS_NO_LINK;
    end else if ({1'b0, count_next} != {2'b00, length_eff} + LEN_EXTRA) begin
      status_code = STATUS_BAD_LEN;
    end else if (crc_next != 16'h0000) begin
      status_code = STATUS_BAD_CRC;
    end else begin
      status_code = STATUS_OK;
    end
    pay_item  = '{is_status: 1'b0, payload_byte: hold_bytes[0],
                  frame_status: STATUS_OK, run_last: 1'b0};
    stat_item = '{is_status: 1'b1, payload_byte: 8'h00,
                  frame_status: status_code, run_last: 1'b1};
    push.a_en = rx_xfer & (emit_payload | rx.frame_end);
    push.b_en = rx_xfer & emit_payload & rx.frame_end;
    push.a    = emit_payload ? pay_item : stat_item;
    push.b    = stat_item;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc         <= CRC_INIT;
      byte_count      <= '0;
      declared_length <= '0;
      hold_count      <= '0;
    end else if (rx_xfer) begin
      if (rx.frame_end) begin
        crc_acc         <= CRC_INIT;
        byte_count      <= '0;
        declared_length <= '0;
        hold_count      <= '0;
      end else begin
        crc_acc         <= crc_next;
        byte_count      <= count_next;
        declared_length <= length_eff;
        if (byte_count != 9'd0 && hold_count != 2'd2) begin
          hold_count <= hold_count + 2'd1;
        end
      end
    end
  end

  // Two-byte delay line, no reset needed
  always_ff @(posedge clk) begin
    if (rx_xfer && byte_count != 9'd0) begin
      if (hold_count == 2'd2) begin
        hold_bytes[0] <= hold_bytes[1];
        hold_bytes[1] <= rx.rx_byte;
      end else begin
        hold_bytes[hold_count[0]] <= rx.rx_byte;
      end
    end
  end

  cfc_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (tx_xfer),
    .head  (head),
    .level (level)
  );

  // Result channel
  assign tx.valid        = (level != 3'd0);
  assign tx.is_status    = head.is_status;
  assign tx.payload_byte = head.payload_byte;
  assign tx.frame_status = head.frame_status;
  assign tx.run_last     = head.run_last;

endmodule

FILE: hw/rtl/cfc_result_fifo.sv
// Four-entry result queue taking up to two items per cycle, one out.
// Depends on cfc_pkg.
module cfc_result_fifo
  import cfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic [2:0] level
);

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr_b;
  logic [2:0] n_push;
  logic [2:0] level_next;

  assign wr_ptr_b   = wr_ptr + 2'd1;
  assign n_push     = {2'b00, push.a_en} + {2'b00, push.b_en};
  assign level_next = level + n_push - {2'b00, pop};
  assign head       = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.a_en) begin
      mem[wr_ptr] <= push.a;
    end
    if (push.b_en) begin
      mem[wr_ptr_b] <= push.b;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      rd_ptr <= rd_ptr + {1'b0, pop};
      level  <= level_next;
    end
  end

endmodule

FILE: tb/sv/crc_frame_checker_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for crc_frame_checker_unit: sends CRC-16/MODBUS framed byte streams
// and checks every result transfer against a scoreboard that predicts them.
// Depends on cfc_pkg, the cfc_if.sv interfaces and the unit itself.
module crc_frame_checker_unit_tb;
  import cfc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 300;

  // Predicts the payload and status items of each accepted byte and
  // matches them against the result transfers in order.
  class frame_result_scoreboard;
    logic          link_up;
    logic [15:0]   crc;
    logic [8:0]    count;
    logic [7:0]    decl_len;
    logic [7:0]    hold [2];
    logic [1:0]    hold_cnt;
    result_t       results_due [$];
    int            errors;

    function new();
      link_up  = 1'b0;
      hold[0]  = 8'h00;
      hold[1]  = 8'h00;
      errors   = 0;
      clear_frame();
    endfunction

    // Reflected CRC-16 update over one byte
    static function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void clear_frame();
      crc      = CRC_INIT;
      count    = 9'd0;
      decl_len = 8'd0;
      hold_cnt = 2'd0;
    endfunction

    function void set_link(input logic v);
      link_up = v;
    endfunction

    function void note_rx_byte(input logic [7:0] b, input logic last);
      result_t       r;
      frame_status_t st;
      crc = crc_step(crc, b);
      // length byte, fill of the delay line, or one byte pushed out
      if (count == 9'd0) begin
        decl_len = b;
      end else if (hold_cnt >= 2'd2) begin
        r.is_status    = 1'b0;
        r.payload_byte = hold[0];
        r.frame_status = STATUS_OK;
        r.run_last     = 1'b0;
        results_due = {results_due, r};
        hold[0] = hold[1];
        hold[1] = b;
      end else begin
        hold[hold_cnt[0]] = b;
        hold_cnt++;
      end
      if (count != COUNT_MAX) count++;
      // status item closes the frame
      if (last) begin
        if (!link_up) begin
          st = STATUS_NO_LINK;
        end else if ({1'b0, count} != {2'b00, decl_len} + LEN_EXTRA) begin
          st = STATUS_BAD_LEN;
        end else if (crc != 16'h0000) begin
          st = STATUS_BAD_CRC;
        end else begin
          st = STATUS_OK;
        end
        r.is_status    = 1'b1;
        r.payload_byte = 8'h00;
        r.frame_status = st;
        r.run_last     = 1'b1;
        results_due = {results_due, r};
        clear_frame();
      end
    endfunction

    function void check_tx_item(input result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result transfer, got %h", $time, got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.is_status !== want.is_status) begin
        $display("%0t: is_status expected %0b got %0b", $time, want.is_status, got.is_status);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte expected %h got %h", $time, want.payload_byte,
                 got.payload_byte);
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $display("%0t: frame_status expected %0d got %0d", $time, want.frame_status,
                 got.frame_status);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %0b got %0b", $time, want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_off_req;

  logic [7:0] frame_bytes [$];
  frame_result_scoreboard sb;

  cfc_cfg_if cfg_ch ();
  cfc_rx_if  rx_ch ();
  cfc_res_if tx_ch ();

  crc_frame_checker_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transfer, prediction noted at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.rx_byte   <= b;
    rx_ch.frame_end <= last;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.note_rx_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic start_frame(input logic [7:0] decl);
    frame_bytes.delete();
    frame_bytes = {frame_bytes, decl};
  endtask

  // Append the CRC low byte first; optionally flip one bit past the length byte
  task automatic seal_frame(input bit corrupt);
    logic [15:0] c;
    int          pos;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = frame_result_scoreboard::crc_step(c, frame_bytes[i]);
    frame_bytes = {frame_bytes, c[7:0]};
    frame_bytes = {frame_bytes, c[15:8]};
    if (corrupt) begin
      pos = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  // Drop valid, wait out every expected result and the trailing latency
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_link(input logic v);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.link_up <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_link(v);
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise
  task automatic run_random_frames(input int byte_budget);
    int sent;
    int kind;
    int n;
    sent = 0;
    while (sent < byte_budget) begin
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (kind < 72) begin
        // good frame, or one with a flipped bit
        start_frame(n[7:0]);
        repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
        seal_frame(kind >= 60);
      end else if (kind < 82) begin
        // declared length off, CRC intact
        start_frame(n[7:0] + 8'($urandom_range(1, 255)));
        repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
        seal_frame(1'b0);
      end else begin
        // short frames and raw noise
        frame_bytes.delete();
        n = (kind < 90) ? $urandom_range(1, 2) : $urandom_range(1, 9);
        repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
      end
      send_frame();
      sent += frame_bytes.size();
    end
  endtask

  // Result side: checks each transfer, stalls at random or on request
  initial begin : tx_sink
    int      stall_left;
    result_t got;
    stall_left = 0;
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tx_ch.valid && tx_ch.ready) begin
        got.is_status    = tx_ch.is_status;
        got.payload_byte = tx_ch.payload_byte;
        got.frame_status = frame_status_t'(tx_ch.frame_status);
        got.run_last     = tx_ch.run_last;
        sb.check_tx_item(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        tx_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        tx_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    rst             <= 1'b1;
    rx_ch.valid     <= 1'b0;
    rx_ch.rx_byte   <= 8'h00;
    rx_ch.frame_end <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.link_up  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // link down: payload still forwarded, status not connected
    write_link(1'b0);
    start_frame(8'd2);
    frame_bytes = {frame_bytes, 8'h00};
    frame_bytes = {frame_bytes, 8'hFF};
    seal_frame(1'b0);
    send_frame();
    settle();

    write_link(1'b1);
    // empty payload
    start_frame(8'd0);
    seal_frame(1'b0);
    send_frame();
    // one payload byte
    start_frame(8'd1);
    frame_bytes = {frame_bytes, 8'hFF};
    seal_frame(1'b0);
    send_frame();
    // bad CRC
    start_frame(8'd1);
    frame_bytes = {frame_bytes, 8'h00};
    seal_frame(1'b1);
    send_frame();
    // bad length with a valid CRC
    start_frame(8'd5);
    frame_bytes = {frame_bytes, 8'h5A};
    seal_frame(1'b0);
    send_frame();
    // one- and two-byte frames
    frame_bytes = {8'hFF};
    send_frame();
    frame_bytes = {8'h02, 8'h00};
    send_frame();
    settle();

    // long receiver hold-off so the result queue fills and rx stalls
    hold_off_req = 1'b1;
    run_random_frames(80);
    settle();

    write_link(1'b0);
    run_random_frames(50);
    settle();

    write_link(1'b1);
    // longest legal frame, sent back to back with no idling
    no_idle = 1'b1;
    start_frame(8'd255);
    repeat (255) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
    seal_frame(1'b0);
    send_frame();
    no_idle = 1'b0;
    run_random_frames(50);
    settle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_if.sv
hw/rtl/cfc_result_fifo.sv
hw/rtl/crc_frame_checker_unit.sv
tb/sv/crc_frame_checker_unit_tb.sv
